// File: rtl/bcc_pkg.sv
package bcc_pkg;

    // Register map (word index into the configuration space)
    localparam int unsigned PADDR_W = 4;
    localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS   = 2'd1;
    localparam logic [1:0] REG_DOUBLE_CLICK = 2'd2;

    // Reset values of the timing registers
    localparam logic [15:0] DEBOUNCE_RESET     = 16'd20;
    localparam logic [15:0] LONG_PRESS_RESET   = 16'd1000;
    localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd0;

    // Item kinds
    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Pin levels (active-low button)
    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    // Event flag masks
    localparam logic [4:0] EV_PRESS   = 5'b00001;
    localparam logic [4:0] EV_SINGLE  = 5'b00010;
    localparam logic [4:0] EV_LONG    = 5'b00100;
    localparam logic [4:0] EV_RELEASE = 5'b01000;
    localparam logic [4:0] EV_DOUBLE  = 5'b10000;

    // Click counter limits
    localparam logic [1:0] CLICKS_ONE = 2'd1;
    localparam logic [1:0] CLICKS_TWO = 2'd2;
    localparam logic [1:0] CLICKS_MAX = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE        = 2'd0,
        MODE_PRESS_DEB   = 2'd1,
        MODE_PRESSED     = 2'd2,
        MODE_RELEASE_DEB = 2'd3
    } mode_t;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] long_press_ticks;
        logic [15:0] double_click_ticks;
    } bcc_cfg_t;

    typedef struct packed {
        logic        operation;
        logic        level;
        logic [31:0] now_ticks;
        logic [4:0]  clear_mask;
    } bcc_item_t;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  click_count;
        logic [4:0]  pending_events;
        logic [31:0] edge_time;
        logic [31:0] release_mark;
        logic        long_held;
    } bcc_state_t;

    // Wrapping time difference compared against a limit
    function automatic logic elapsed(logic [31:0] now, logic [31:0] since,
                                     logic [15:0] limit);
        logic [31:0] diff;
        diff = now - since;
        return diff >= {16'd0, limit};
    endfunction

endpackage

// File: rtl/bcc_cfg.sv
module bcc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output bcc_pkg::bcc_cfg_t           cfg
);

    bcc_pkg::bcc_cfg_t cfg_reg;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks     <= bcc_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ticks   <= bcc_pkg::LONG_PRESS_RESET;
            cfg_reg.double_click_ticks <= bcc_pkg::DOUBLE_CLICK_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                bcc_pkg::REG_DEBOUNCE:     cfg_reg.debounce_ticks     <= pwdata[15:0];
                bcc_pkg::REG_LONG_PRESS:   cfg_reg.long_press_ticks   <= pwdata[15:0];
                bcc_pkg::REG_DOUBLE_CLICK: cfg_reg.double_click_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        unique case (reg_idx)
            bcc_pkg::REG_DEBOUNCE:     prdata = {16'd0, cfg_reg.debounce_ticks};
            bcc_pkg::REG_LONG_PRESS:   prdata = {16'd0, cfg_reg.long_press_ticks};
            bcc_pkg::REG_DOUBLE_CLICK: prdata = {16'd0, cfg_reg.double_click_ticks};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/bcc_step.sv
module bcc_step (
    input  bcc_pkg::bcc_cfg_t   cfg,
    input  bcc_pkg::bcc_item_t  item,
    input  bcc_pkg::bcc_state_t cur,
    output bcc_pkg::bcc_state_t nxt
);

    logic deb_done;
    logic long_done;
    logic dbl_done;

    assign deb_done  = bcc_pkg::elapsed(item.now_ticks, cur.edge_time, cfg.debounce_ticks);
    assign long_done = bcc_pkg::elapsed(item.now_ticks, cur.edge_time, cfg.long_press_ticks);
    assign dbl_done  = bcc_pkg::elapsed(item.now_ticks, cur.release_mark,
                                        cfg.double_click_ticks);

    // Next state of the classifier for one item
    always_comb
    begin
        nxt = cur;
        if (item.operation == bcc_pkg::OP_CLEAR)
        begin
            nxt.pending_events = cur.pending_events & ~item.clear_mask;
        end
        else
        begin
            unique case (cur.mode)
                bcc_pkg::MODE_IDLE:
                begin
                    // lone click times out into a single
                    if (cur.click_count == bcc_pkg::CLICKS_ONE && dbl_done)
                    begin
                        nxt.pending_events = cur.pending_events | bcc_pkg::EV_SINGLE;
                        nxt.click_count    = 2'd0;
                    end
                    if (item.level == bcc_pkg::LEVEL_PRESSED)
                    begin
                        nxt.mode      = bcc_pkg::MODE_PRESS_DEB;
                        nxt.edge_time = item.now_ticks;
                    end
                end
                bcc_pkg::MODE_PRESS_DEB:
                begin
                    if (deb_done)
                    begin
                        if (item.level == bcc_pkg::LEVEL_PRESSED)
                        begin
                            // press overwrites all pending flags
                            nxt.pending_events = bcc_pkg::EV_PRESS;
                            nxt.mode           = bcc_pkg::MODE_PRESSED;
                        end
                        else
                        begin
                            nxt.mode = bcc_pkg::MODE_IDLE;
                        end
                    end
                end
                bcc_pkg::MODE_PRESSED:
                begin
                    if (item.level == bcc_pkg::LEVEL_RELEASED)
                    begin
                        nxt.mode      = bcc_pkg::MODE_RELEASE_DEB;
                        nxt.edge_time = item.now_ticks;
                        if (!cur.long_held && cur.click_count != bcc_pkg::CLICKS_MAX)
                            nxt.click_count = cur.click_count + 2'd1;
                    end
                    else if (long_done)
                    begin
                        nxt.pending_events = cur.pending_events | bcc_pkg::EV_LONG;
                        nxt.long_held      = 1'b1;
                    end
                end
                bcc_pkg::MODE_RELEASE_DEB:
                begin
                    // release taken as confirmed at expiry whatever the level
                    if (deb_done)
                    begin
                        nxt.mode           = bcc_pkg::MODE_IDLE;
                        nxt.pending_events = cur.pending_events | bcc_pkg::EV_RELEASE;
                        if (cur.long_held)
                        begin
                            nxt.long_held   = 1'b0;
                            nxt.click_count = 2'd0;
                        end
                        else if (cur.click_count == bcc_pkg::CLICKS_ONE)
                        begin
                            nxt.release_mark = item.now_ticks;
                        end
                        else if (cur.click_count >= bcc_pkg::CLICKS_TWO)
                        begin
                            nxt.pending_events = cur.pending_events | bcc_pkg::EV_RELEASE
                                               | bcc_pkg::EV_DOUBLE;
                            nxt.click_count    = 2'd0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/button_click_classifier_core.sv
// Push-button click classifier for an active-low pin.
// Input stream (s_*): one transfer per item. s_tuser is the operation
// (0 scan, 1 clear flags); s_tdata carries level, a 32-bit tick stamp and
// the clear mask. Output stream (m_*): one transfer per input item, m_tdata
// holding the five sticky event flags after that item (press, single, long,
// release, double click).
// Timing registers are written over the APB port at byte addresses 0, 4, 8
// (debounce, long press, double-click window); the user must write them only
// while the block is idle, which the block itself does not enforce. An
// accepted item is held in the input register, classified as it moves into
// the result register, and offered on m_tvalid from there. Throughput: one
// item per cycle while the receiver takes results, set by the single
// classifier update between the input register and the result register.
// Reset: timing registers return to 20, 1000 and 0 ticks, the classifier
// goes idle with no flags and no clicks, and both stages are empty.
// A stalled receiver holds the result register; the input register still
// takes one more item, after which s_tready drops until the result moves.
module button_click_classifier_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,  // level, now_ticks[31:0], clear_mask[4:0], pad
    input  logic                        s_tuser,  // operation
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,  // events[4:0], pad
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    bcc_pkg::bcc_cfg_t   cfg;
    bcc_pkg::bcc_item_t  item_reg;
    logic                in_valid_reg;
    bcc_pkg::bcc_state_t state_reg;
    bcc_pkg::bcc_state_t state_next;
    logic [4:0]          events_reg;
    logic                out_valid_reg;
    logic                out_free;
    logic                advance;

    bcc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcc_step u_step (
        .cfg  (cfg),
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    // Handshake between the two stages
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.operation  <= s_tuser;
            item_reg.level      <= s_tdata[0];
            item_reg.now_ticks  <= s_tdata[32:1];
            item_reg.clear_mask <= s_tdata[37:33];
        end
    end

    // Classifier state, updated as each item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode           <= bcc_pkg::MODE_IDLE;
            state_reg.click_count    <= 2'd0;
            state_reg.pending_events <= 5'd0;
            state_reg.edge_time      <= 32'd0;
            state_reg.release_mark   <= 32'd0;
            state_reg.long_held      <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            events_reg <= state_next.pending_events;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, events_reg};

    // long press flag only lives while the button is down or releasing
    a_long_held_mode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.long_held |-> (state_reg.mode == bcc_pkg::MODE_PRESSED ||
                                 state_reg.mode == bcc_pkg::MODE_RELEASE_DEB))
        else $error("long_held outside a press");

    // state moves only when an item is handed to the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("classifier state changed without a transfer");

    // a held input item is not dropped while the result side is stalled
    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(item_reg)))
        else $error("pending input item lost");

endmodule

// File: tb/bcc_flag_checker.sv
module bcc_flag_checker
    import bcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [39:0]          s_tdata,   // level, now_ticks[31:0], clear_mask[4:0], pad
    input  logic                 s_tuser,   // operation
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [7:0]           m_tdata,   // events[4:0], pad
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    input  logic                 drain_done,
    output int                   fail_count,
    output int                   in_flight,
    output int                   results_checked,
    output logic [4:0]           flags_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the timing registers and the classifier state
    bcc_cfg_t    timing;
    mode_t       mode;
    logic [1:0]  clicks;
    logic [4:0]  flags;
    logic [31:0] edge_at;
    logic [31:0] first_release_at;
    logic        long_seen;

    logic [4:0]  flags_due[$];

    // Wrapping tick distance against a 16-bit limit
    function automatic logic waited(input logic [31:0] now, input logic [31:0] since,
                                    input logic [15:0] limit);
        logic [31:0] gap;
        gap = now - since;
        return gap >= {16'd0, limit};
    endfunction

    // Flags after one item; updates the shadow state
    function automatic logic [4:0] next_flags(input bcc_item_t it);
        if (it.operation == OP_CLEAR)
        begin
            flags = flags & ~it.clear_mask;
            return flags;
        end
        case (mode)
            MODE_IDLE:
            begin
                if (clicks == CLICKS_ONE &&
                    waited(it.now_ticks, first_release_at, timing.double_click_ticks))
                begin
                    flags  = flags | EV_SINGLE;
                    clicks = 2'd0;
                end
                if (it.level == LEVEL_PRESSED)
                begin
                    mode    = MODE_PRESS_DEB;
                    edge_at = it.now_ticks;
                end
            end
            MODE_PRESS_DEB:
            begin
                if (waited(it.now_ticks, edge_at, timing.debounce_ticks))
                begin
                    if (it.level == LEVEL_PRESSED)
                    begin
                        // confirmed press wipes whatever was pending
                        flags = EV_PRESS;
                        mode  = MODE_PRESSED;
                    end
                    else
                        mode = MODE_IDLE;
                end
            end
            MODE_PRESSED:
            begin
                if (it.level == LEVEL_RELEASED)
                begin
                    mode    = MODE_RELEASE_DEB;
                    edge_at = it.now_ticks;
                    if (!long_seen && clicks != CLICKS_MAX)
                        clicks = clicks + 2'd1;
                end
                else if (waited(it.now_ticks, edge_at, timing.long_press_ticks))
                begin
                    flags     = flags | EV_LONG;
                    long_seen = 1'b1;
                end
            end
            default:
            begin
                // release taken at expiry regardless of the level
                if (waited(it.now_ticks, edge_at, timing.debounce_ticks))
                begin
                    flags = flags | EV_RELEASE;
                    if (long_seen)
                    begin
                        long_seen = 1'b0;
                        clicks    = 2'd0;
                    end
                    else if (clicks == CLICKS_ONE)
                        first_release_at = it.now_ticks;
                    else if (clicks >= CLICKS_TWO)
                    begin
                        flags  = flags | EV_DOUBLE;
                        clicks = 2'd0;
                    end
                    mode = MODE_IDLE;
                end
            end
        endcase
        return flags;
    endfunction

    // Register writes, result compare, then prediction of the new transfer
    always @(posedge clk or negedge rst_n)
    begin
        bcc_item_t  it;
        logic [4:0] want;
        if (!rst_n)
        begin
            timing.debounce_ticks     = DEBOUNCE_RESET;
            timing.long_press_ticks   = LONG_PRESS_RESET;
            timing.double_click_ticks = DOUBLE_CLICK_RESET;
            mode             = MODE_IDLE;
            clicks           = 2'd0;
            flags            = 5'd0;
            edge_at          = 32'd0;
            first_release_at = 32'd0;
            long_seen        = 1'b0;
            flags_due.delete();
            in_flight        = 0;
            fail_count       = 0;
            results_checked  = 0;
            flags_seen       = 5'd0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_DEBOUNCE:     timing.debounce_ticks     = pwdata[15:0];
                    REG_LONG_PRESS:   timing.long_press_ticks   = pwdata[15:0];
                    REG_DOUBLE_CLICK: timing.double_click_ticks = pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                flags_seen = flags_seen | m_tdata[4:0];
                if (flags_due.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, events %05b",
                             $realtime, m_tdata[4:0]);
                    fail_count++;
                end
                else
                begin
                    want = flags_due.pop_front();
                    results_checked++;
                    if (m_tdata[4:0] !== want)
                    begin
                        $display("%0t: events mismatch, expected %05b got %05b",
                                 $realtime, want, m_tdata[4:0]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                it.operation  = s_tuser;
                it.level      = s_tdata[0];
                it.now_ticks  = s_tdata[32:1];
                it.clear_mask = s_tdata[37:33];
                flags_due.push_back(next_flags(it));
            end
            in_flight = flags_due.size();
        end
    end

    // Anything still owed once the stream has drained is lost
    always @(posedge drain_done)
    begin
        if (flags_due.size() != 0)
        begin
            $display("%0t: %0d results never arrived, oldest expected %05b",
                     $realtime, flags_due.size(), flags_due[0]);
            fail_count++;
        end
    end

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bcc_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_OFF    = 300;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [39:0]         s_tdata;   // level, now_ticks[31:0], clear_mask[4:0], pad
    logic                s_tuser;   // operation
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;   // events[4:0], pad
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    logic                drain_done;
    logic                s_taken;
    logic                want_hold;
    int                  fail_count;
    int                  in_flight;
    int                  results_checked;
    logic [4:0]          flags_seen;

    int                  snd_idle_pct;
    int                  rcv_idle_pct;
    int                  items_sent;
    int                  quiet_cycles;
    logic [31:0]         tick_now;
    int unsigned         deb;
    int unsigned         lng;
    int unsigned         dbl;

    button_click_classifier_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bcc_flag_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .drain_done      (drain_done),
        .fail_count      (fail_count),
        .in_flight       (in_flight),
        .results_checked (results_checked),
        .flags_seen      (flags_seen)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Input transfer seen at the last rising edge, read at the falling edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_taken <= 1'b0;
        else
            s_taken <= s_tvalid && s_tready;
    end

    // Watchdog on cycles with no transfer of any kind
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $realtime, quiet_cycles, in_flight);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result receiver: random back-pressure plus one long hold-off
    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (want_hold && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(negedge clk);
                hold_done = 1'b1;
            end
            else
                m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // One input transfer, with random sender gaps in front
    task automatic put_item(input logic op, input logic lvl, input logic [31:0] t,
                            input logic [4:0] mask);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, mask, t, lvl};
        @(negedge clk);
        while (!s_taken)
            @(negedge clk);
        items_sent++;
    endtask

    task automatic scan_after(input logic lvl, input int unsigned step);
        tick_now = tick_now + step;
        put_item(OP_SCAN, lvl, tick_now, 5'($urandom_range(31)));
    endtask

    // n scans at one level; the first comes soon, the rest cover the span
    task automatic hold_level(input logic lvl, input int unsigned span, input int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++)
        begin
            if (k == 0)
                scan_after(lvl, 1 + $urandom_range(20));
            else
                scan_after(lvl, span / (n - 1) + $urandom_range(2));
        end
    endtask

    // Stop offering and wait until every result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_timing(input int unsigned d, input int unsigned l, input int unsigned w);
        settle();
        deb = d;
        lng = l;
        dbl = w;
        reg_write(REG_DEBOUNCE, d[15:0]);
        reg_write(REG_LONG_PRESS, l[15:0]);
        reg_write(REG_DOUBLE_CLICK, w[15:0]);
    endtask

    // Short press then release; the release span decides single or double
    task automatic short_click(input logic quick_gap);
        int unsigned room;
        int unsigned gap;
        room = (lng > deb + 4) ? lng - deb - 4 : 1;
        gap  = quick_gap ? $urandom_range(dbl / 2) : dbl + 1 + $urandom_range(300);
        hold_level(LEVEL_PRESSED, deb + $urandom_range(room), 2 + $urandom_range(4));
        hold_level(LEVEL_RELEASED, deb + gap, 2 + $urandom_range(3));
    endtask

    // One random episode: mostly well-formed gestures, some bounce and noise
    task automatic episode();
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(99);
        if (pick < 30)
            short_click(1'($urandom_range(1)));
        else if (pick < 50)
        begin
            short_click(1'b1);
            short_click(1'($urandom_range(1)));
        end
        else if (pick < 65)
        begin
            hold_level(LEVEL_PRESSED, lng + deb + $urandom_range(200), 3 + $urandom_range(3));
            hold_level(LEVEL_RELEASED, deb + $urandom_range(100), 2 + $urandom_range(2));
        end
        else if (pick < 75)
        begin
            // contact bounce shorter than the debounce time
            for (k = 0; k < 2 + $urandom_range(3); k++)
                scan_after(1'($urandom_range(1)), $urandom_range(deb / 2 + 1));
        end
        else if (pick < 85)
            put_item(OP_CLEAR, 1'($urandom_range(1)), $urandom, 5'($urandom_range(31)));
        else
        begin
            for (k = 0; k < 1 + $urandom_range(3); k++)
            begin
                case ($urandom_range(3))
                    0:       tick_now = $urandom;
                    1:       tick_now = tick_now + $urandom;
                    default: tick_now = tick_now + $urandom_range(2 * deb + 10);
                endcase
                put_item(1'($urandom_range(1)), 1'($urandom_range(1)), tick_now,
                         5'($urandom_range(31)));
            end
        end
    endtask

    task automatic run_random(input int target);
        while (items_sent < target)
            episode();
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_SCAN;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        drain_done   = 1'b0;
        want_hold    = 1'b0;
        items_sent   = 0;
        snd_idle_pct = 32;
        rcv_idle_pct = 50;
        deb          = 32'(DEBOUNCE_RESET);
        lng          = 32'(LONG_PRESS_RESET);
        dbl          = 32'(DOUBLE_CLICK_RESET);
        tick_now     = 32'd0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset timing, wrap of the tick counter, long press,
        // release confirmed while pressed, aborted press, flag overwrite
        put_item(OP_CLEAR, LEVEL_RELEASED, 32'd0, 5'h00);
        put_item(OP_SCAN, LEVEL_RELEASED, 32'd0, 5'h1F);
        tick_now = 32'hFFFF_FFF0;
        scan_after(LEVEL_PRESSED, 0);
        scan_after(LEVEL_PRESSED, 32);       // press confirmed across the wrap
        scan_after(LEVEL_PRESSED, 1000);     // long press
        scan_after(LEVEL_PRESSED, 1);        // long press raised again
        scan_after(LEVEL_RELEASED, 5);
        scan_after(LEVEL_PRESSED, 10);
        scan_after(LEVEL_PRESSED, 10);       // release taken though pressed
        put_item(OP_CLEAR, LEVEL_PRESSED, 32'hFFFF_FFFF, EV_LONG);
        scan_after(LEVEL_PRESSED, 1);
        scan_after(LEVEL_RELEASED, 30);      // press debounce aborted
        scan_after(LEVEL_PRESSED, 1);
        scan_after(LEVEL_PRESSED, 20);       // exactly at the limit: press wipes release
        scan_after(LEVEL_RELEASED, 100);
        scan_after(LEVEL_RELEASED, 20);
        scan_after(LEVEL_RELEASED, 1);       // single with no window
        put_item(OP_CLEAR, LEVEL_RELEASED, tick_now, 5'h1F);

        // Directed: double click inside a window
        set_timing(32'(DEBOUNCE_RESET), 32'(LONG_PRESS_RESET), 500);
        scan_after(LEVEL_PRESSED, 1);
        scan_after(LEVEL_PRESSED, 20);
        scan_after(LEVEL_RELEASED, 50);
        scan_after(LEVEL_RELEASED, 20);
        scan_after(LEVEL_RELEASED, 100);     // still inside the window
        scan_after(LEVEL_PRESSED, 10);
        scan_after(LEVEL_PRESSED, 20);
        scan_after(LEVEL_RELEASED, 30);
        scan_after(LEVEL_RELEASED, 20);      // double click

        // Random, sender 32 / receiver 50
        set_timing($urandom_range(40), 200 + $urandom_range(600), 100 + $urandom_range(300));
        tick_now = $urandom;
        run_random(items_sent + 300);

        // Random at the extremes, sender 50 / receiver 32
        snd_idle_pct = 50;
        rcv_idle_pct = 32;
        set_timing(0, 0, 0);
        run_random(items_sent + 100);
        set_timing(65535, 65535, 65535);
        tick_now = $urandom;
        run_random(items_sent + 100);

        // No idling; the receiver holds off once while items keep coming
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_timing(1 + $urandom_range(30), 100 + $urandom_range(400), $urandom_range(200));
        want_hold <= 1'b1;
        run_random(items_sent + 300);
        set_timing($urandom_range(60), $urandom_range(2000), $urandom_range(1000));
        tick_now = $urandom;
        run_random(1150);

        settle();
        repeat (6) @(negedge clk);
        drain_done <= 1'b1;
        @(negedge clk);

        $display("Summary: %0d items sent, %0d results compared; event flags seen %05b",
                 items_sent, results_checked, flags_seen);
        $display("Timing covered reset values, random settings and both 0 and 65535 limits");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
